// ----- hdl/sliding_window_min_max_mean_macros.svh -----
// ----------------------------------------------------------------------------
// Sliding window statistics: assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmm checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmm checker: next-cycle property failed");

`endif

// ----- hdl/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window statistics: package
// Shared widths, types and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int COUNT_OUT_W      = 8;
    localparam int DEF_WINDOW_DEPTH = 200;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_OUT_W-1:0]     t_count_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming sample
        logic rd_old;      // read the slot that is about to be overwritten
        logic upd;         // write the sample, update sum, count and slot
        logic scan_start;  // rewind the scan index
        logic scan;        // read one stored sample for the min/max scan
        logic div_start;   // launch the serial divider
        logic out_load;    // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // the scan index points at the last held sample
        logic div_busy;    // the divider is iterating
        logic out_free;    // the result register can take a new result
    } t_stat;

endpackage

// ----- hdl/swmm_ifs.sv -----
// ----------------------------------------------------------------------------
// Sliding window statistics: channel interfaces
// Valid/ready channels for the sample input and the statistics result.
// ----------------------------------------------------------------------------
interface swmm_smp_if
    import swmm_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface swmm_res_if
    import swmm_pkg::*;
();
    logic       valid;
    logic       ready;
    t_count_out held_count;
    t_sample    window_mean;
    t_sample    window_min;
    t_sample    window_max;

    modport source (output valid, output held_count, output window_mean,
                    output window_min, output window_max, input ready);
    modport sink (input valid, input held_count, input window_mean,
                  input window_min, input window_max, output ready);
endinterface

// ----- hdl/swmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sliding window statistics: controller
// Sequences one sample through update, window scan, divide and result load.
// ----------------------------------------------------------------------------
module swmm_ctrl
    import swmm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RD_OLD   = 3'd1;
    localparam logic [2:0] ST_UPD      = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_SCAN_END = 3'd4;
    localparam logic [2:0] ST_DIV      = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD_OLD;
                end
            end
            ST_RD_OLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd        = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                // The last scan read is compared during this cycle.
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/swmm_dp.sv -----
// ----------------------------------------------------------------------------
// Sliding window statistics: datapath
// Ring store, running sum, min/max scan, serial divider and result register.
// ----------------------------------------------------------------------------
module swmm_dp
    import swmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_sample    i_sample,
    input  logic       i_out_ready,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output t_count_out o_held_count,
    output t_sample    o_window_mean,
    output t_sample    o_window_min,
    output t_sample    o_window_max
);

    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = SAMPLE_W + CW;
    localparam int STW = $clog2(SW + 1);

    localparam logic [AW-1:0]  SLOT_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0]  COUNT_MAX = CW'(WINDOW_DEPTH);
    localparam logic [CW-1:0]  COUNT_ONE = CW'(1);
    localparam logic [STW-1:0] STEPS     = STW'(SW);
    localparam logic [STW-1:0] STEP_ONE  = STW'(1);

    // Sample store.
    t_sample mem [WINDOW_DEPTH];
    t_sample r_rdata;
    logic [AW-1:0] rd_addr;

    // Window state.
    t_sample             r_sample;
    logic [AW-1:0]       r_slot;
    logic [CW-1:0]       r_count;
    logic signed [SW-1:0] r_sum;
    logic                full;

    // Scan.
    logic [AW-1:0] r_idx;
    logic          r_cmp_vld;
    logic          r_cmp_first;
    t_sample       r_min;
    t_sample       r_max;

    // Divider.
    logic           r_div_busy;
    logic [STW-1:0] r_step;
    logic [SW-1:0]  r_quo;
    logic [CW:0]    r_rem;
    logic           r_neg;
    logic [CW:0]    rem_sh;
    logic           rem_ge;

    // Result register.
    logic r_out_vld;

    assign full    = (r_count == COUNT_MAX);
    assign rd_addr = i_cmd.rd_old ? r_slot : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            mem[r_slot] <= r_sample;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
    end

    // Window bookkeeping. When the window is full, r_rdata holds the oldest
    // sample, read from the slot about to be overwritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.upd) begin
            r_sum   <= r_sum - (full ? SW'(r_rdata) : SW'(0)) + SW'(r_sample);
            r_count <= full ? r_count : r_count + COUNT_ONE;
            r_slot  <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
        end
    end

    // Min/max scan: reads are issued one per cycle and compared in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_first <= 1'b0;
        end else begin
            r_cmp_vld   <= i_cmd.scan;
            r_cmp_first <= i_cmd.scan && (r_idx == '0);
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld) begin
            if (r_cmp_first || (r_rdata < r_min)) begin
                r_min <= r_rdata;
            end
            if (r_cmp_first || (r_rdata > r_max)) begin
                r_max <= r_rdata;
            end
        end
    end

    // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
    assign rem_sh = {r_rem[CW-1:0], r_quo[SW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_step     <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_step     <= STEPS;
        end else if (r_div_busy) begin
            r_step     <= r_step - STEP_ONE;
            r_div_busy <= (r_step != STEP_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SW-1];
            r_quo <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
            r_rem <= '0;
        end else if (r_div_busy) begin
            r_rem <= rem_ge ? rem_sh - {1'b0, r_count} : rem_sh;
            r_quo <= {r_quo[SW-2:0], rem_ge};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_held_count  <= COUNT_OUT_W'(r_count);
            o_window_mean <= r_neg ? -r_quo[SAMPLE_W-1:0] : r_quo[SAMPLE_W-1:0];
            o_window_min  <= r_min;
            o_window_max  <= r_max;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_stat.scan_last = (CW'(r_idx) == (r_count - COUNT_ONE));
    assign o_stat.div_busy  = r_div_busy;
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

endmodule

// ----- hdl/sliding_window_min_max_mean.sv -----
// ----------------------------------------------------------------------------
// Sliding window minimum, maximum and mean
// Usage:
//   i_smp carries one signed Q8.8 sample per transfer. o_res carries one
//   result per sample: the number of samples held, their mean (truncated
//   toward zero), and the window minimum and maximum.
//   The window holds the last WINDOW_DEPTH samples in a two-port ring
//   memory; once full, the oldest sample leaves the running sum.
//   The running sum is SW = 16 + clog2(WINDOW_DEPTH + 1) bits wide (24 at
//   the default depth). The memory read port scans the window one sample a
//   cycle, then a serial divider takes one quotient bit a cycle. One sample
//   is processed at a time; i_smp.ready is high while the block is idle,
//   also while a result waits in the output register.
//   Reset empties the window and drops any pending result; the memory needs
//   no clearing because only written slots are read.
//   If the receiver stalls, the result is held and the next sample is
//   accepted, but its result waits until the previous one is taken.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean
    import swmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swmm_smp_if.sink    i_smp,
    swmm_res_if.source  o_res
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    swmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swmm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_smp.sample),
        .i_out_ready   (o_res.ready),
        .o_stat        (stat),
        .o_out_valid   (o_res.valid),
        .o_held_count  (o_res.held_count),
        .o_window_mean (o_res.window_mean),
        .o_window_min  (o_res.window_min),
        .o_window_max  (o_res.window_max)
    );

    assign i_smp.ready = in_ready;

endmodule

// ----- hdl/swmm_chk.sv -----
// ----------------------------------------------------------------------------
// Sliding window statistics: port checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_mean_macros.svh"

module swmm_chk
    import swmm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_sample    i_window_mean,
    input t_sample    i_window_min,
    input t_sample    i_window_max
);

    // Samples are processed one at a time.
    `SWMM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result stays valid and unchanged.
    `SWMM_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_window_mean) && $stable(i_window_min) && $stable(i_window_max))

    // The minimum never exceeds the maximum.
    `SWMM_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, i_out_valid, i_window_min <= i_window_max)

    // The truncated mean lies within the window's range.
    `SWMM_ASSERT_NOW(a_mean_in_range, i_clk, i_rst_n, i_out_valid, (i_window_min <= i_window_mean) && (i_window_mean <= i_window_max))

endmodule

bind sliding_window_min_max_mean swmm_chk u_swmm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_smp.valid),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_window_mean (o_res.window_mean),
    .i_window_min  (o_res.window_min),
    .i_window_max  (o_res.window_max)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window minimum, maximum and mean: testbench
// Sends signed Q8.8 samples over the valid/ready input channel. An
// independent window model tracks the ring store, count and running sum. For
// every accepted sample it predicts the count, mean, minimum and maximum, and
// each result transfer is compared field by field with the oldest
// prediction. The stimulus covers field extremes, mean truncation, window wrap
// at full depth, a long output stall and random bursts with idle gaps.
// ----------------------------------------------------------------------------
module testbench;
    import swmm_pkg::*;

    localparam int     WINDOW_DEPTH    = DEF_WINDOW_DEPTH;
    localparam int     SUM_W           = SAMPLE_W + $clog2(WINDOW_DEPTH + 1);
    localparam int     MAX_LATENCY     = WINDOW_DEPTH + SUM_W + 5;
    localparam int     HOLD_OFF_CYCLES = 4 * MAX_LATENCY;
    localparam int     RANDOM_SEGMENTS = 30;
    localparam int     SEGMENT_ITEMS   = 50;
    localparam longint CYCLE_LIMIT     = 4000000;

    typedef struct packed {
        t_count_out held_count;
        t_sample    window_mean;
        t_sample    window_min;
        t_sample    window_max;
    } t_window_stats;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swmm_smp_if smp_ch ();
    swmm_res_if res_ch ();

    sliding_window_min_max_mean #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch)
    );

    // Window model state, owned by the checker process.
    t_window_stats expected_stats[$];
    t_sample       win_store [WINDOW_DEPTH];
    int            win_slot;
    int            win_fill;
    longint        win_sum;
    int            error_count = 0;
    longint        cycle_count = 0;

    // Traffic shaping, owned by the stimulus process.
    bit sender_gaps;
    bit rx_stalls;
    int burst_left;
    int hold_off_requests;
    int walk_value;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic check_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_window_stats want;
        int            lowest;
        int            highest;
        if (!i_rst_n) begin
            win_slot = 0;
            win_fill = 0;
            win_sum  = 0;
            expected_stats.delete();
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                // On a full window the write slot holds the oldest sample.
                if (win_fill == WINDOW_DEPTH)
                    win_sum -= win_store[win_slot];
                else
                    win_fill++;
                win_store[win_slot] = smp_ch.sample;
                win_sum += smp_ch.sample;
                win_slot = (win_slot + 1 == WINDOW_DEPTH) ? 0 : win_slot + 1;
                lowest  = win_store[0];
                highest = win_store[0];
                for (int k = 1; k < win_fill; k++) begin
                    if (win_store[k] < lowest)
                        lowest = win_store[k];
                    if (win_store[k] > highest)
                        highest = win_store[k];
                end
                want.held_count  = t_count_out'(win_fill);
                want.window_mean = t_sample'(win_sum / win_fill);
                want.window_min  = t_sample'(lowest);
                want.window_max  = t_sample'(highest);
                expected_stats.insert(expected_stats.size(), want);
            end
            if (res_ch.valid === 1'b1 && res_ch.ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual count %0d",
                             $time, res_ch.held_count);
                    error_count++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("held_count", want.held_count, res_ch.held_count);
                    check_field("window_mean", want.window_mean, res_ch.window_mean);
                    check_field("window_min", want.window_min, res_ch.window_min);
                    check_field("window_max", want.window_max, res_ch.window_max);
                end
            end
        end
    end

    // Result receiver: a long hold-off on request, otherwise either always
    // ready or alternating runs of ready and stall of random length.
    initial begin : receiver
        int served;
        int hold_left;
        int run_left;
        bit level;
        served    = 0;
        hold_left = 0;
        run_left  = 0;
        level     = 1'b1;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_requests != served) begin
                served    = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!rx_stalls) begin
                res_ch.ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    level    = !level;
                    run_left = level ? $urandom_range(1, 24) : $urandom_range(1, 10);
                end
                run_left--;
                res_ch.ready <= level;
            end
        end
    end

    // Called and returns at a falling edge. Valid is left high so that the
    // next call can continue the burst without a gap.
    task automatic send_sample(input t_sample value);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                smp_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        @(posedge i_clk);
        while (!smp_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        smp_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_stats.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        t_sample corners [17];
        sender_gaps = 1'b0;
        rx_stalls   = 1'b1;
        // The first three samples give sums of -3 over 2 and -1 over 3, so the
        // mean must truncate toward zero rather than round down.
        corners = '{16'shFFFD, 16'sh0000, 16'sh0002, 16'sh8000, 16'sh7FFF, 16'shFFFF,
                    16'sh0001, 16'sh5555, 16'shAAAA, 16'sh0100, 16'shFF00, 16'sh7F00,
                    16'sh8100, 16'sh00FF, 16'shFF01, 16'sh8001, 16'sh7FFE};
        foreach (corners[i])
            send_sample(corners[i]);
    endtask

    task automatic test_window_wrap();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b1;
        // Fill the whole window with the top value, then push it all out with
        // the bottom value: the sum reaches both extremes and the maximum only
        // drops when the last top value leaves.
        repeat (WINDOW_DEPTH)
            send_sample(16'sh7FFF);
        repeat (WINDOW_DEPTH)
            send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
    endtask

    task automatic test_back_pressure();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        wait_for_results();
        // The receiver holds off long enough for one result to wait in the
        // output register, a second to finish behind it, and the input to stall.
        hold_off_requests++;
        repeat (6)
            send_sample(t_sample'($urandom_range(0, 65535)));
        wait_for_results();
    endtask

    task automatic test_random_bursts();
        int v;
        int pick;
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            sender_gaps = $urandom_range(0, 3) != 0;
            rx_stalls   = $urandom_range(0, 3) != 0;
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    v = $urandom_range(0, 65535);
                end else if (pick < 6) begin
                    v = $urandom_range(0, 128);
                    v -= 64;
                end else if (pick == 6) begin
                    v = $urandom_range(0, 3);
                    v = $urandom_range(0, 1) ? 32767 - v : v - 32768;
                end else begin
                    // Slowly drifting reading, as a real sensor would give.
                    v = $urandom_range(0, 512);
                    walk_value += v - 256;
                    if (walk_value > 32767)
                        walk_value = 32767;
                    if (walk_value < -32768)
                        walk_value = -32768;
                    v = walk_value;
                end
                send_sample(t_sample'(v));
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        smp_ch.valid      = 1'b0;
        smp_ch.sample     = '0;
        sender_gaps       = 1'b0;
        rx_stalls         = 1'b0;
        burst_left        = 0;
        hold_off_requests = 0;
        walk_value        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_window_wrap();
        test_back_pressure();
        test_random_bursts();

        wait_for_results();
        repeat (2 * MAX_LATENCY) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sliding_window_min_max_mean.f -----
+incdir+hdl
hdl/swmm_pkg.sv
hdl/swmm_ifs.sv
hdl/swmm_ctrl.sv
hdl/swmm_dp.sv
hdl/sliding_window_min_max_mean.sv
hdl/swmm_chk.sv
sim/testbench.sv
